@@ hw/rtl/fir_filter_stream_assert.svh @@
// Assertion macros for the FIR filter block.
// Properties are sampled on the rising edge of clk and disabled while rst_n is low.
`ifndef FIR_FILTER_STREAM_ASSERT_SVH
`define FIR_FILTER_STREAM_ASSERT_SVH

`ifndef SYNTH
`define FIR_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("fir assertion failed");
`define FIR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fir assertion failed");
`else
`define FIR_ASSERT(lbl, expr)
`define FIR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ hw/rtl/fir_pkg.sv @@
`default_nettype none

package fir_pkg;

    localparam int TAPS           = 64;
    localparam int SAMPLE_BITS    = 16;
    localparam int COEF_BITS      = 16;
    localparam int COEF_FRAC      = 15;
    localparam int ADDR_BITS      = $clog2(TAPS);
    localparam int TAP_CNT_BITS   = 7;
    localparam int COEF_IDX_BITS  = 6;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int PROD_BITS      = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_BITS       = PROD_BITS + ADDR_BITS;
    localparam int Q_BITS         = ACC_BITS + 1 - COEF_FRAC;

    localparam logic signed [ACC_BITS:0]   ROUND_HALF = (ACC_BITS+1)'(2 ** (COEF_FRAC - 1));
    localparam logic signed [Q_BITS-1:0]   Q_MAX      = Q_BITS'(2 ** (SAMPLE_BITS - 1) - 1);
    localparam logic signed [Q_BITS-1:0]   Q_MIN      = ~Q_MAX;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_TAP_COUNT  = 2'd0,
        REG_COEF_INDEX = 2'd1,
        REG_COEF_VALUE = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic                 start;
        logic                 issue;
        logic [ADDR_BITS-1:0] tap;
        logic                 load_out;
    } fir_cmd_t;

    typedef struct packed {
        logic                 pipe_busy;
        logic [ADDR_BITS-1:0] last_tap;
    } fir_sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/fir_datapath.sv @@
`default_nettype none

module fir_datapath (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire fir_pkg::fir_cmd_t                          cmd,
    output fir_pkg::fir_sts_t                               sts,
    input  wire logic signed [fir_pkg::SAMPLE_BITS-1:0]     sample_in,
    input  wire logic                                       cfg_we,
    input  wire logic [fir_pkg::CFG_INDEX_BITS-1:0]         cfg_index,
    input  wire logic [fir_pkg::CFG_DATA_BITS-1:0]          cfg_data,
    output logic signed [fir_pkg::SAMPLE_BITS-1:0]          sample_out,
    output logic                                            clipped
);

    logic [fir_pkg::TAP_CNT_BITS-1:0]       tap_count_reg;
    logic [fir_pkg::COEF_IDX_BITS-1:0]      coef_index_reg;
    logic                                   coef_wr;

    logic signed [fir_pkg::SAMPLE_BITS-1:0] hist_mem [fir_pkg::TAPS];
    logic signed [fir_pkg::COEF_BITS-1:0]   coef_mem [fir_pkg::TAPS];
    logic [fir_pkg::TAPS-1:0]               coef_vld_reg;

    logic [fir_pkg::ADDR_BITS-1:0]          wptr_reg;
    logic [fir_pkg::ADDR_BITS:0]            fill_reg;
    logic [fir_pkg::ADDR_BITS-1:0]          rd_addr;
    logic                                   tap_ok;

    logic signed [fir_pkg::SAMPLE_BITS-1:0] hist_rd_reg;
    logic signed [fir_pkg::COEF_BITS-1:0]   coef_rd_reg;
    logic                                   tap_ok_reg;
    logic                                   p1_vld_reg;
    logic signed [fir_pkg::PROD_BITS-1:0]   prod_c;
    logic signed [fir_pkg::PROD_BITS-1:0]   prod_reg;
    logic                                   p2_vld_reg;
    logic signed [fir_pkg::ACC_BITS-1:0]    acc_reg;

    logic [fir_pkg::TAP_CNT_BITS-1:0]       tc_m1;
    logic [fir_pkg::ADDR_BITS-1:0]          tap_last;
    logic signed [fir_pkg::ACC_BITS:0]      rsum;
    logic signed [fir_pkg::Q_BITS-1:0]      rq;
    logic signed [fir_pkg::SAMPLE_BITS-1:0] sample_out_reg;
    logic                                   clipped_reg;

    assign coef_wr = cfg_we && (cfg_index == fir_pkg::REG_COEF_VALUE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg  <= fir_pkg::TAP_CNT_BITS'(1);
            coef_index_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fir_pkg::REG_TAP_COUNT:
                    tap_count_reg <= cfg_data[fir_pkg::TAP_CNT_BITS-1:0];
                fir_pkg::REG_COEF_INDEX:
                    coef_index_reg <= cfg_data[fir_pkg::COEF_IDX_BITS-1:0];
                default:
                    ;
            endcase
        end
    end

    // zero taps behave as one, anything above the store depth as the full store
    assign tc_m1 = tap_count_reg - fir_pkg::TAP_CNT_BITS'(1);

    always_comb
    begin
        priority if (tap_count_reg == '0)
            tap_last = '0;
        else if (tap_count_reg > fir_pkg::TAP_CNT_BITS'(fir_pkg::TAPS))
            tap_last = fir_pkg::ADDR_BITS'(fir_pkg::TAPS - 1);
        else
            tap_last = tc_m1[fir_pkg::ADDR_BITS-1:0];
    end

    assign sts = '{pipe_busy: p1_vld_reg | p2_vld_reg, last_tap: tap_last};

    // history is a circular buffer; the newest sample sits just behind wptr
    assign rd_addr = wptr_reg - fir_pkg::ADDR_BITS'(1) - cmd.tap;
    // history slots never written yet and coefficients never loaded read as zero
    assign tap_ok  = ({1'b0, cmd.tap} < fill_reg) && coef_vld_reg[cmd.tap];
    assign prod_c  = fir_pkg::PROD_BITS'(hist_rd_reg) * fir_pkg::PROD_BITS'(coef_rd_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.start)
            hist_mem[wptr_reg] <= sample_in;
        if (coef_wr)
            coef_mem[coef_index_reg] <= cfg_data;
        if (cmd.issue)
        begin
            hist_rd_reg <= hist_mem[rd_addr];
            coef_rd_reg <= coef_mem[cmd.tap];
            tap_ok_reg  <= tap_ok;
        end
        if (p1_vld_reg)
            prod_reg <= tap_ok_reg ? prod_c : '0;
        if (cmd.start)
            acc_reg <= '0;
        else if (p2_vld_reg)
            acc_reg <= acc_reg + fir_pkg::ACC_BITS'(prod_reg);
        if (cmd.load_out)
        begin
            priority if (rq > fir_pkg::Q_MAX)
            begin
                sample_out_reg <= fir_pkg::Q_MAX[fir_pkg::SAMPLE_BITS-1:0];
                clipped_reg    <= 1'b1;
            end
            else if (rq < fir_pkg::Q_MIN)
            begin
                sample_out_reg <= fir_pkg::Q_MIN[fir_pkg::SAMPLE_BITS-1:0];
                clipped_reg    <= 1'b1;
            end
            else
            begin
                sample_out_reg <= rq[fir_pkg::SAMPLE_BITS-1:0];
                clipped_reg    <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_vld_reg <= '0;
            wptr_reg     <= '0;
            fill_reg     <= '0;
            p1_vld_reg   <= 1'b0;
            p2_vld_reg   <= 1'b0;
        end
        else
        begin
            if (coef_wr)
                coef_vld_reg[coef_index_reg] <= 1'b1;
            if (cmd.start)
            begin
                wptr_reg <= wptr_reg + fir_pkg::ADDR_BITS'(1);
                if (fill_reg != (fir_pkg::ADDR_BITS+1)'(fir_pkg::TAPS))
                    fill_reg <= fill_reg + (fir_pkg::ADDR_BITS+1)'(1);
            end
            p1_vld_reg <= cmd.issue;
            p2_vld_reg <= p1_vld_reg;
        end
    end

    // round half up, then floor shift back to the sample format
    assign rsum = (fir_pkg::ACC_BITS+1)'(acc_reg) + fir_pkg::ROUND_HALF;
    assign rq   = rsum[fir_pkg::ACC_BITS:fir_pkg::COEF_FRAC];

    assign sample_out = sample_out_reg;
    assign clipped    = clipped_reg;

endmodule

`default_nettype wire

@@ hw/rtl/fir_ctrl.sv @@
`default_nettype none

module fir_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output fir_pkg::fir_cmd_t      cmd,
    input  wire fir_pkg::fir_sts_t sts
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_FIN
    } state_t;

    state_t                        state_reg;
    state_t                        state_next;
    logic [fir_pkg::ADDR_BITS-1:0] tap_reg;
    logic [fir_pkg::ADDR_BITS-1:0] tap_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic                          out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        tap_next       = tap_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.tap        = tap_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    tap_next   = '0;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                cmd.issue = 1'b1;
                if (tap_reg == sts.last_tap)
                    state_next = S_DRAIN;
                else
                    tap_next = tap_reg + fir_pkg::ADDR_BITS'(1);
            end
            S_DRAIN:
            begin
                if (!sts.pipe_busy)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                // hold the sum until the output register is free
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tap_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tap_reg       <= tap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

@@ hw/rtl/fir_filter_stream.sv @@
// Streaming FIR filter, up to 64 taps, Q1.15 samples and coefficients.
// Input channel in_valid/in_ready carries sample_in; output channel
// out_valid/out_ready carries sample_out and clipped (set when the rounded
// sum was saturated). One result per input transaction, in order.
// Coefficients load through cfg_we/cfg_index/cfg_data while idle: index 0
// tap_count, 1 coef_index, 2 coef_value (stored at coef_index).
// Each sample takes one multiply-accumulate per tap through a single
// multiplier fed from the sample and coefficient memories: an input
// transaction is accepted, the taps up to the effective tap count are
// issued, the read, product and accumulate stages drain, and the rounded
// sum is loaded into the output register, which raises out_valid. A new
// sample is accepted only once the previous one has been loaded there.
// A finished result waits in the output register; the next sample is still
// accepted and computed, and stalls before its own output load only while
// the previous result is not yet taken.
// Reset clears the history fill count and coefficient valid flags, so both
// read as zero; tap_count resets to 1. No clearing pass is needed.
`default_nettype none

module fir_filter_stream (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic signed [fir_pkg::SAMPLE_BITS-1:0] sample_in,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic signed [fir_pkg::SAMPLE_BITS-1:0]      sample_out,
    output logic                                        clipped,
    input  wire logic                                   cfg_we,
    input  wire logic [fir_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  wire logic [fir_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

`include "fir_filter_stream_assert.svh"

    fir_pkg::fir_cmd_t cmd;
    fir_pkg::fir_sts_t sts;

    fir_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    fir_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .sample_in  (sample_in),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample_out (sample_out),
        .clipped    (clipped)
    );

    `FIR_ASSERT(a_start_pipe_empty, !(cmd.start && sts.pipe_busy))
    `FIR_ASSERT(a_load_pipe_empty, !(cmd.load_out && sts.pipe_busy))
    `FIR_ASSERT(a_start_not_issue, !(cmd.start && cmd.issue))
    `FIR_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

endmodule

`default_nettype wire

@@ test/fir_filter_stream_tb.sv @@
`timescale 1ns / 1ps

module fir_filter_stream_tb;
    import fir_pkg::*;

    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 154;
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 600;
    localparam int REPORT_MAX  = 10;

    // index 3 decodes to nothing in the block
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 2'd3;

    localparam longint OUT_MAX = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint OUT_MIN = -OUT_MAX - 1;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          clip;
    } filtered_t;

    class fir_output_track;
        logic signed [SAMPLE_BITS-1:0] history[TAPS];
        logic signed [COEF_BITS-1:0]   coefs[TAPS];
        logic [TAP_CNT_BITS-1:0]       tap_count;
        logic [COEF_IDX_BITS-1:0]      coef_slot;
        filtered_t                     pending_outputs[$];
        int                            mismatches;
        int                            outputs_seen;
        int                            clips_seen;

        function new();
            int k;
            for (k = 0; k < TAPS; k++)
            begin
                history[k] = '0;
                coefs[k]   = '0;
            end
            tap_count    = 7'd1;
            coef_slot    = '0;
            mismatches   = 0;
            outputs_seen = 0;
            clips_seen   = 0;
        endfunction

        function void take_write(logic [CFG_INDEX_BITS-1:0] idx,
                                 logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                REG_TAP_COUNT:  tap_count = data[TAP_CNT_BITS-1:0];
                REG_COEF_INDEX: coef_slot = data[COEF_IDX_BITS-1:0];
                REG_COEF_VALUE: coefs[coef_slot] = data[COEF_BITS-1:0];
                default: ;
            endcase
        endfunction

        // shift the new sample in and form the rounded, saturated sum
        function void take_sample(logic signed [SAMPLE_BITS-1:0] s);
            int        k;
            int        n;
            longint    acc;
            longint    y;
            filtered_t r;
            if (tap_count == 0)
                n = 1;
            else if (tap_count > TAPS)
                n = TAPS;
            else
                n = tap_count;
            for (k = TAPS - 1; k > 0; k--)
                history[k] = history[k-1];
            history[0] = s;
            acc = 0;
            for (k = 0; k < n; k++)
                acc += longint'(history[k]) * longint'(coefs[k]);
            y = (acc + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
            r.clip = 1'b0;
            if (y > OUT_MAX)
            begin
                y      = OUT_MAX;
                r.clip = 1'b1;
            end
            else if (y < OUT_MIN)
            begin
                y      = OUT_MIN;
                r.clip = 1'b1;
            end
            r.sample = y[SAMPLE_BITS-1:0];
            pending_outputs.push_back(r);
        endfunction

        function void match_output(logic signed [SAMPLE_BITS-1:0] s, logic c);
            filtered_t r;
            outputs_seen++;
            if (c)
                clips_seen++;
            if (pending_outputs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected output transaction: sample %0d clipped %0b",
                             s, c);
                return;
            end
            r = pending_outputs.pop_front();
            if (s !== r.sample || c !== r.clip)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("output %0d wrong: expected sample %0d clipped %0b, got %0d %0b",
                             outputs_seen, r.sample, r.clip, s, c);
            end
        endfunction
    endclass

    logic                          clk        = 1'b0;
    logic                          rst_n      = 1'b0;
    logic                          in_valid   = 1'b0;
    logic                          in_ready;
    logic signed [SAMPLE_BITS-1:0] sample_in  = '0;
    logic                          out_valid;
    logic                          out_ready  = 1'b0;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          clipped;
    logic                          cfg_we     = 1'b0;
    logic [CFG_INDEX_BITS-1:0]     cfg_index  = '0;
    logic [CFG_DATA_BITS-1:0]      cfg_data   = '0;

    fir_output_track tracker;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_request   = 0;
    int samples_sent   = 0;
    int tap_settings   = 0;
    int quiet_cycles   = 0;

    fir_filter_stream u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .clipped    (clipped),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("stalled: no transaction for %0d cycles", QUIET_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // output side: check each transaction, then pick the next ready
    initial
    begin : output_sink
        int hold_left;
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                tracker.match_output(sample_out, clipped);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic cfg_write(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        tracker.take_write(idx, data);
        if (idx == REG_TAP_COUNT)
            tap_settings++;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_coef(input int k, input logic [COEF_BITS-1:0] c);
        // junk above the index field is dropped by the block
        cfg_write(REG_COEF_INDEX, {10'($urandom), 6'(k)});
        cfg_write(REG_COEF_VALUE, c);
    endtask

    task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] s);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        sample_in <= s;
        do
            @(posedge clk);
        while (!in_ready);
        tracker.take_sample(s);
        samples_sent++;
    endtask

    task automatic wait_idle(input int settle);
        in_valid <= 1'b0;
        while (tracker.pending_outputs.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 9))
            6:
                case ($urandom_range(0, 4))
                    0: return 16'sh7FFF;
                    1: return 16'sh8000;
                    2: return 16'sh0000;
                    3: return 16'shFFFF;
                    default: return 16'sh0001;
                endcase
            7, 8, 9: return 16'($urandom_range(0, 511)) - 16'sd256;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic load_coefs(input int profile, input int eff_taps);
        int                   k;
        int                   span;
        logic [COEF_BITS-1:0] c;
        span = 32768 / eff_taps;
        for (k = 0; k < TAPS; k++)
        begin
            case (profile)
                0: c = 16'($urandom);
                1: c = 16'($urandom_range(0, 2 * span - 1) - span);
                default:
                    if ($urandom_range(0, 7) != 0)
                        c = '0;
                    else
                        case ($urandom_range(0, 3))
                            0: c = 16'h7FFF;
                            1: c = 16'h8000;
                            2: c = 16'h4000;
                            default: c = 16'hC000;
                        endcase
            endcase
            set_coef(k, c);
        end
    endtask

    task automatic run_directed();
        int k;
        // coefficient store is clear after reset
        push_sample(16'sh7FFF);
        push_sample(16'sh8000);
        wait_idle(8);
        set_coef(0, 16'h8000);
        push_sample(16'sh8000);
        push_sample(16'sh7FFF);
        push_sample(16'sd1);
        push_sample(-16'sd1);
        push_sample(16'sd0);
        wait_idle(8);
        // half a unit either side of zero: ties go upwards
        set_coef(0, 16'h4000);
        push_sample(16'sd1);
        push_sample(-16'sd1);
        push_sample(16'sd3);
        push_sample(-16'sd3);
        wait_idle(8);
        set_coef(1, 16'h7FFF);
        cfg_write(REG_SPARE, 16'hFFFF);
        cfg_write(REG_TAP_COUNT, 16'd0);
        push_sample(16'sd5);
        wait_idle(8);
        for (k = 0; k < TAPS; k++)
            set_coef(k, 16'h7FFF);
        cfg_write(REG_TAP_COUNT, 16'h007F);
        repeat (3) push_sample(16'sh7FFF);
        repeat (3) push_sample(16'sh8000);
        wait_idle(8);
        cfg_write(REG_TAP_COUNT, 16'd64);
        push_sample(16'sh8000);
        push_sample(16'sh7FFF);
        wait_idle(8);
    endtask

    task automatic run_phase(input int p);
        int taps;
        int eff;
        int i;
        case (p)
            0: taps = 1;
            1: taps = 64;
            2: taps = 0;
            3: taps = 127;
            4, 5: taps = $urandom_range(2, 16);
            6: taps = $urandom_range(17, 63);
            default: taps = $urandom_range(65, 126);
        endcase
        eff = (taps == 0) ? 1 : (taps > TAPS) ? TAPS : taps;
        case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
            default: begin send_idle_pct = 35; recv_stall_pct = 35; end
        endcase
        wait_idle(8);
        cfg_write(REG_SPARE, 16'($urandom));
        // upper data bits are outside the tap count field
        cfg_write(REG_TAP_COUNT, 16'($urandom_range(0, 511) << TAP_CNT_BITS) | 16'(taps));
        load_coefs(p % 3, eff);
        for (i = 0; i < PHASE_ITEMS; i++)
        begin
            if (p == 0 && i == 40)
                hold_request = HOLD_CYCLES;
            push_sample(pick_sample());
        end
    endtask

    initial
    begin : stimulus
        int p;
        tracker = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        for (p = 0; p < PHASES; p++)
            run_phase(p);
        wait_idle(80);
        $display("Sent %0d samples across %0d tap count settings; %0d outputs checked, %0d clipped.",
                 samples_sent, tap_settings, tracker.outputs_seen, tracker.clips_seen);
        $display("Idle and stall mixes on both channels plus one long output hold-off; %0d mismatches.",
                 tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.pending_outputs.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
